@@ hw/rtl/tcce_pkg.sv @@
// ----------------------------------------------------------------------------
// tcce_pkg: shared definitions for the text console engine
// Geometry, byte codes, request and register codes, the sequencer state type
// and the text RAM write bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

	// Screen and text memory geometry
	localparam int COLUMNS      = 80;
	localparam int ROWS         = 25;
	localparam int MEMORY_CELLS = 8192;
	localparam int ADDR_W       = $clog2(MEMORY_CELLS);
	localparam int SPAN         = ROWS * COLUMNS;
	// window bases at or above this must be copied down before a scroll
	localparam int SCROLL_LIMIT = MEMORY_CELLS - SPAN - COLUMNS;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int CELL_W = 16;
	localparam int ATTR_W = 8;
	localparam int CFG_W  = 1;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CELL_W-1:0] cell_t;

	// Request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_CLEAR = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_W-1:0] CFG_CHAR_ATTR  = 1'b0;
	localparam logic [CFG_W-1:0] CFG_BLANK_CELL = 1'b1;

	localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;
	localparam cell_t             BLANK_RESET = 16'h0720;

	// Console byte codes
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_ENQ = 8'h05;
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_HT  = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_DEL = 8'h7F;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BYTE,
		ST_LF,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_FILL,
		ST_POST,
		ST_RD_WAIT,
		ST_CLEAR,
		ST_DONE
	} state_t;

	// Text RAM write port bundle
	typedef struct packed {
		logic  en;
		addr_t addr;
		cell_t data;
	} ram_wr_t;

endpackage

`default_nettype wire

@@ hw/rtl/tcce_ram.sv @@
// ----------------------------------------------------------------------------
// tcce_ram: text cell memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_ram (
	input  wire              clk,
	input  tcce_pkg::ram_wr_t wr,
	input  tcce_pkg::addr_t   raddr,
	output tcce_pkg::cell_t   rdata
);
	import tcce_pkg::*;

	cell_t mem [MEMORY_CELLS];

	// write first in program order, read registered
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/tcce_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcce_ctrl: console sequencer
// Decodes requests and bytes, keeps the window, write position and cursor,
// drives the text RAM for prints, erases, scroll copy/fill and clears, and
// holds the result item in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_ctrl (
	input  wire                            clk,
	input  wire                            arst_n,
	// request channel
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire  [1:0]                     req_type,
	input  wire  [7:0]                     char_byte,
	input  wire                            last_byte,
	input  wire  [tcce_pkg::ADDR_W-1:0]    read_addr,
	// configuration writes
	input  wire                            cfg_we,
	input  wire  [tcce_pkg::CFG_W-1:0]     cfg_index,
	input  wire  [tcce_pkg::CELL_W-1:0]    cfg_data,
	// result channel
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [tcce_pkg::ADDR_W-1:0]    screen_start,
	output logic [tcce_pkg::ADDR_W-1:0]    cursor_cell,
	output logic                           beep,
	output logic [tcce_pkg::CELL_W-1:0]    read_cell,
	// text RAM
	output tcce_pkg::ram_wr_t              ram_wr,
	output tcce_pkg::addr_t                ram_raddr,
	input  tcce_pkg::cell_t                ram_rdata
);
	import tcce_pkg::*;

	state_t state_q, state_n;

	// console state
	addr_t             wb_q, wb_n;     // window base
	addr_t             wc_q, wc_n;     // write position
	logic [COL_W-1:0]  col_q, col_n;
	logic [ROW_W-1:0]  row_q, row_n;
	addr_t             cur_q, cur_n;   // cursor register
	logic [ATTR_W-1:0] attr_q;
	cell_t             blank_q;

	// item being worked on
	logic [1:0]        req_q, req_n;
	logic [7:0]        ch_q, ch_n;
	logic              last_q, last_n;
	logic              beep_q, beep_n;
	cell_t             rd_q, rd_n;
	addr_t             cnt_q, cnt_n;

	// output register
	logic              out_valid_q;
	addr_t             start_q;
	addr_t             cursor_q;
	logic              obeep_q;
	cell_t             ocell_q;
	logic              load_out;

	cell_t             print_cell;

	assign print_cell = {attr_q, ch_q};

	// next state, RAM control and item bookkeeping
	always_comb begin
		state_n   = state_q;
		wb_n      = wb_q;
		wc_n      = wc_q;
		col_n     = col_q;
		row_n     = row_q;
		cur_n     = cur_q;
		req_n     = req_q;
		ch_n      = ch_q;
		last_n    = last_q;
		beep_n    = beep_q;
		rd_n      = rd_q;
		cnt_n     = cnt_q;
		ram_wr    = '0;
		ram_raddr = wb_q + cnt_q;
		in_ready  = 1'b0;
		load_out  = 1'b0;

		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				ram_raddr = read_addr;
				if (in_valid) begin
					req_n  = req_type;
					ch_n   = char_byte;
					last_n = last_byte;
					beep_n = 1'b0;
					rd_n   = '0;
					cnt_n  = '0;
					case (req_type)
						REQ_WRITE: state_n = ST_BYTE;
						REQ_CLEAR: begin
							wb_n    = '0;
							wc_n    = '0;
							col_n   = '0;
							row_n   = '0;
							cur_n   = '0;
							state_n = ST_CLEAR;
						end
						REQ_READ: state_n = ST_RD_WAIT;
						default:  state_n = ST_DONE;
					endcase
				end
			end

			ST_BYTE: begin
				state_n = ST_DONE;
				case (ch_q)
					CH_NUL, CH_ENQ, CH_HT, CH_VT, CH_ESC: ;
					CH_BEL: beep_n = 1'b1;
					CH_BS: begin
						if (col_q != '0) begin
							col_n        = col_q - COL_W'(1);
							wc_n         = wc_q - ADDR_W'(1);
							ram_wr.en    = 1'b1;
							ram_wr.addr  = wc_q - ADDR_W'(1);
							ram_wr.data  = blank_q;
						end
					end
					CH_LF, CH_FF: state_n = ST_LF;
					CH_CR: begin
						wc_n  = wc_q - ADDR_W'(col_q);
						col_n = '0;
					end
					CH_DEL: begin
						ram_wr.en   = 1'b1;
						ram_wr.addr = wc_q;
						ram_wr.data = blank_q;
					end
					default: begin
						if (col_q >= COL_W'(COLUMNS)) begin
							// line full: back to its start, then new line
							col_n   = col_q - COL_W'(COLUMNS);
							wc_n    = wc_q - ADDR_W'(COLUMNS);
							state_n = ST_LF;
						end else begin
							ram_wr.en   = 1'b1;
							ram_wr.addr = wc_q;
							ram_wr.data = print_cell;
							wc_n        = wc_q + ADDR_W'(1);
							col_n       = col_q + COL_W'(1);
						end
					end
				endcase
			end

			// line feed: next row, or scroll on the last row
			ST_LF: begin
				cnt_n = '0;
				if (row_q < ROW_W'(ROWS - 1)) begin
					row_n   = row_q + ROW_W'(1);
					wc_n    = wc_q + ADDR_W'(COLUMNS);
					state_n = ST_POST;
				end else if (wb_q >= ADDR_W'(SCROLL_LIMIT)) begin
					state_n = ST_COPY_RD;
				end else begin
					state_n = ST_FILL;
				end
			end

			// window copy to cell 0, one cell per read/write pair
			ST_COPY_RD: state_n = ST_COPY_WR;

			ST_COPY_WR: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = cnt_q;
				ram_wr.data = ram_rdata;
				if (cnt_q == ADDR_W'(SPAN - 1)) begin
					wc_n    = wc_q - wb_q;
					wb_n    = '0;
					cnt_n   = '0;
					state_n = ST_FILL;
				end else begin
					cnt_n   = cnt_q + ADDR_W'(1);
					state_n = ST_COPY_RD;
				end
			end

			// blank the row below the window, then move the window down
			ST_FILL: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = wb_q + ADDR_W'(SPAN) + cnt_q;
				ram_wr.data = blank_q;
				if (cnt_q == ADDR_W'(COLUMNS - 1)) begin
					wb_n    = wb_q + ADDR_W'(COLUMNS);
					wc_n    = wc_q + ADDR_W'(COLUMNS);
					state_n = ST_POST;
				end else begin
					cnt_n = cnt_q + ADDR_W'(1);
				end
			end

			// after the line feed: carriage return for LF, nothing for FF, print for a wrap
			ST_POST: begin
				state_n = ST_DONE;
				if (ch_q == CH_LF) begin
					wc_n  = wc_q - ADDR_W'(col_q);
					col_n = '0;
				end else if (ch_q != CH_FF) begin
					ram_wr.en   = 1'b1;
					ram_wr.addr = wc_q;
					ram_wr.data = print_cell;
					wc_n        = wc_q + ADDR_W'(1);
					col_n       = col_q + COL_W'(1);
				end
			end

			ST_RD_WAIT: begin
				rd_n    = ram_rdata;
				state_n = ST_DONE;
			end

			ST_CLEAR: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = cnt_q;
				ram_wr.data = blank_q;
				if (cnt_q == ADDR_W'(MEMORY_CELLS - 1)) begin
					state_n = ST_DONE;
				end else begin
					cnt_n = cnt_q + ADDR_W'(1);
				end
			end

			// hand the result over once the output register is free
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					if ((req_q == REQ_WRITE) && last_q) begin
						cur_n = wc_q;
					end
					state_n = ST_IDLE;
				end
			end

			default: state_n = ST_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wb_q        <= '0;
			wc_q        <= '0;
			col_q       <= '0;
			row_q       <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			wb_q    <= wb_n;
			wc_q    <= wc_n;
			col_q   <= col_n;
			row_q   <= row_n;
			cur_q   <= cur_n;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q  <= ATTR_RESET;
			blank_q <= BLANK_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHAR_ATTR:  attr_q  <= cfg_data[ATTR_W-1:0];
				CFG_BLANK_CELL: blank_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		req_q  <= req_n;
		ch_q   <= ch_n;
		last_q <= last_n;
		beep_q <= beep_n;
		rd_q   <= rd_n;
		cnt_q  <= cnt_n;
		if (load_out) begin
			start_q  <= wb_q;
			cursor_q <= cur_n;
			obeep_q  <= beep_q;
			ocell_q  <= rd_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign screen_start = start_q;
	assign cursor_cell  = cursor_q;
	assign beep         = obeep_q;
	assign read_cell    = ocell_q;

endmodule

`default_nettype wire

@@ hw/rtl/text_console_cursor_engine_unit.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit: text-mode console engine
// Sequencer plus an 8192-cell text RAM.
// ----------------------------------------------------------------------------
// One item is handled at a time; the result is held in an output register so
// the next item can be accepted while it waits. A byte that needs no line feed
// goes through the byte step alone; a line feed without scroll adds the line
// feed and post steps; a scroll adds a row fill, preceded by a copy of the
// window to cell 0 when needed (one cell per read/write pair over the text RAM
// ports); a read waits for the registered RAM read data; a clear sweeps the
// whole RAM. The cursor register is loaded when a write item marked as last
// byte completes.
`default_nettype none

module text_console_cursor_engine_unit (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire  [1:0]                  req_type,
	input  wire  [7:0]                  char_byte,
	input  wire                         last_byte,
	input  wire  [tcce_pkg::ADDR_W-1:0] read_addr,
	input  wire                         cfg_we,
	input  wire  [tcce_pkg::CFG_W-1:0]  cfg_index,
	input  wire  [tcce_pkg::CELL_W-1:0] cfg_data,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [tcce_pkg::ADDR_W-1:0] screen_start,
	output logic [tcce_pkg::ADDR_W-1:0] cursor_cell,
	output logic                        beep,
	output logic [tcce_pkg::CELL_W-1:0] read_cell
);
	import tcce_pkg::*;

	ram_wr_t ram_wr;
	addr_t   ram_raddr;
	cell_t   ram_rdata;

	// sequencer
	tcce_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.char_byte    (char_byte),
		.last_byte    (last_byte),
		.read_addr    (read_addr),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.screen_start (screen_start),
		.cursor_cell  (cursor_cell),
		.beep         (beep),
		.read_cell    (read_cell),
		.ram_wr       (ram_wr),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata)
	);

	// text memory
	tcce_ram u_ram (
		.clk   (clk),
		.wr    (ram_wr),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

`default_nettype wire

@@ hw/rtl/tcce_checker.sv @@
// ----------------------------------------------------------------------------
// tcce_checker: port-level checks for the text console engine
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         in_valid,
	input wire                         in_ready,
	input wire                         out_valid,
	input wire                         out_ready,
	input wire [tcce_pkg::ADDR_W-1:0]  screen_start,
	input wire [tcce_pkg::ADDR_W-1:0]  cursor_cell,
	input wire                         beep,
	input wire [tcce_pkg::CELL_W-1:0]  read_cell
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(screen_start) && $stable(cursor_cell)
			&& $stable(beep) && $stable(read_cell))
		else $error("result payload changed while stalled");

	// one item at a time: busy right after an item is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while the previous one is in work");

	// a beep comes from a write, which never returns cell data
	a_beep_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beep |-> read_cell == '0)
		else $error("beep together with read data");

endmodule

bind text_console_cursor_engine_unit tcce_checker u_tcce_checker (.*);

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for text_console_cursor_engine_unit
// Drives request items over a valid/ready channel and predicts each result
// with a behavioural console model: printing, wrap, line feed, scroll with
// copy-down, erase, clear and cell read-back. Each result is checked field by
// field. Phases vary the register settings and the idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcce_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic [1:0] req;
		logic [7:0] ch;
		logic       last;
		addr_t      addr;
	} request_t;

	typedef struct {
		addr_t start;
		addr_t cursor;
		logic  bell;
		cell_t rd;
	} result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         req_type = '0;
	logic [7:0]         char_byte = '0;
	logic               last_byte = 1'b0;
	addr_t              read_addr = '0;
	logic               cfg_we = 1'b0;
	logic [CFG_W-1:0]   cfg_index = '0;
	cell_t              cfg_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	addr_t              screen_start;
	addr_t              cursor_cell;
	logic               beep;
	cell_t              read_cell;

	text_console_cursor_engine_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.char_byte    (char_byte),
		.last_byte    (last_byte),
		.read_addr    (read_addr),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.screen_start (screen_start),
		.cursor_cell  (cursor_cell),
		.beep         (beep),
		.read_cell    (read_cell)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	request_t request_q [$];
	result_t  result_q [$];
	request_t cur_req;
	result_t  oldest;
	int       n_errors = 0;
	int       results_seen = 0;
	int       src_idle_pct = 0;
	int       snk_stall_pct = 0;
	logic     hold_on = 1'b0;
	int       hold_cnt = 0;

	// Console model state
	cell_t       text_mem [MEMORY_CELLS];
	addr_t       win_base;
	addr_t       wr_pos;
	addr_t       cur_reg;
	int unsigned col;
	int unsigned row_idx;
	logic [7:0]  attr_m;
	cell_t       blank_m;

	// Line feed; on the last row the window scrolls, copied down first if needed
	function automatic void feed_line();
		int i;
		if (row_idx + 1 < ROWS) begin
			row_idx++;
			wr_pos = addr_t'(int'(wr_pos) + COLUMNS);
		end else begin
			if (int'(win_base) + SPAN + COLUMNS >= MEMORY_CELLS) begin
				for (i = 0; i < SPAN; i++)
					text_mem[i] = text_mem[addr_t'(int'(win_base) + i)];
				wr_pos = wr_pos - win_base;
				win_base = '0;
			end
			for (i = 0; i < COLUMNS; i++)
				text_mem[addr_t'(int'(win_base) + SPAN + i)] = blank_m;
			win_base = addr_t'(int'(win_base) + COLUMNS);
			wr_pos = addr_t'(int'(wr_pos) + COLUMNS);
		end
	endfunction

	function automatic void return_carriage();
		wr_pos = wr_pos - addr_t'(col);
		col = 0;
	endfunction

	// Apply one accepted item to the model and queue its expected result
	function automatic void console_apply(input request_t rq);
		result_t r;
		int i;
		r.bell = 1'b0;
		r.rd = '0;
		case (rq.req)
			REQ_WRITE: begin
				case (rq.ch)
					CH_NUL, CH_ENQ, CH_HT, CH_VT, CH_ESC: ;
					CH_BEL: r.bell = 1'b1;
					CH_BS: begin
						if (col > 0) begin
							col--;
							wr_pos = wr_pos - 1'b1;
							text_mem[wr_pos] = blank_m;
						end
					end
					CH_LF: begin
						feed_line();
						return_carriage();
					end
					CH_FF: feed_line();
					CH_CR: return_carriage();
					CH_DEL: text_mem[wr_pos] = blank_m;
					default: begin
						// past the right edge: start of next line first
						if (col >= COLUMNS) begin
							col -= COLUMNS;
							wr_pos = addr_t'(int'(wr_pos) - COLUMNS);
							feed_line();
						end
						text_mem[wr_pos] = {attr_m, rq.ch};
						wr_pos = wr_pos + 1'b1;
						col++;
					end
				endcase
				if (rq.last)
					cur_reg = wr_pos;
			end
			REQ_CLEAR: begin
				win_base = '0;
				wr_pos = '0;
				col = 0;
				row_idx = 0;
				cur_reg = '0;
				for (i = 0; i < MEMORY_CELLS; i++)
					text_mem[i] = blank_m;
			end
			REQ_READ: r.rd = text_mem[rq.addr];
			default: ;
		endcase
		r.start = win_base;
		r.cursor = cur_reg;
		result_q.push_back(r);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (n_errors < 100)
			$display("%0t ns: result %0d %s: got 0x%0h, expected 0x%0h",
				$time, results_seen, what, got, want);
		n_errors++;
	endtask

	task automatic push_req(input logic [1:0] req, input logic [7:0] ch, input logic last,
		input addr_t addr);
		request_t rq;
		rq.req = req;
		rq.ch = ch;
		rq.last = last;
		rq.addr = addr;
		request_q.push_back(rq);
	endtask

	// Random traffic: mostly lines of text, each ended by a control byte or a random byte, some noise
	task automatic gen_traffic(input int n_items, input int lf_pct, input int clr_pct,
		input int short_max, input int long_pct);
		int done;
		int kind;
		int len;
		int k;
		logic [7:0] b;
		done = 0;
		while (done < n_items) begin
			kind = $urandom_range(0, 99);
			if (kind < clr_pct) begin
				push_req(REQ_CLEAR, 8'($urandom), 1'($urandom), addr_t'($urandom));
				done++;
			end else if (kind < clr_pct + 8) begin
				push_req(REQ_READ, 8'($urandom), 1'($urandom), addr_t'($urandom));
				done++;
			end else if (kind < clr_pct + 10) begin
				push_req(REQ_UNUSED, 8'($urandom), 1'($urandom), addr_t'($urandom));
				done++;
			end else begin
				len = ($urandom_range(0, 99) < long_pct) ? $urandom_range(60, 100)
					: $urandom_range(0, short_max);
				for (k = 0; k < len; k++) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: b = 8'($urandom_range(8'h20, 8'h7E));
						6, 7:             b = 8'($urandom_range(8'h80, 8'hFF));
						default:          b = 8'($urandom);
					endcase
					push_req(REQ_WRITE, b, ($urandom_range(0, 15) == 0), addr_t'($urandom));
				end
				// line terminator
				if ($urandom_range(0, 99) < lf_pct)
					b = CH_LF;
				else begin
					case ($urandom_range(0, 11))
						0:       b = CH_FF;
						1:       b = CH_CR;
						2:       b = CH_BS;
						3:       b = CH_DEL;
						4:       b = CH_BEL;
						5:       b = CH_NUL;
						6:       b = CH_ENQ;
						7:       b = CH_HT;
						8:       b = CH_VT;
						9:       b = CH_ESC;
						default: b = 8'($urandom);
					endcase
				end
				push_req(REQ_WRITE, b, 1'b1, addr_t'($urandom));
				done += len + 1;
			end
		end
	endtask

	// Wait until every item has gone in and every result has come back
	task automatic wait_idle();
		while (request_q.size() != 0 || in_valid || result_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_W-1:0] idx, input cell_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CHAR_ATTR)
			attr_m = val[ATTR_W-1:0];
		else
			blank_m = val;
		@(negedge clk);
	endtask

	// Sender: offers queued items, holds each until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				console_apply(cur_req);
			if (!in_valid || in_ready) begin
				if (request_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					cur_req = request_q.pop_front();
					in_valid <= 1'b1;
					req_type <= cur_req.req;
					char_byte <= cur_req.ch;
					last_byte <= cur_req.last;
					read_addr <= cur_req.addr;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks results against the oldest prediction, stalls at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					report_mismatch("result with none expected", 0, 0);
				end else begin
					oldest = result_q.pop_front();
					if (screen_start !== oldest.start)
						report_mismatch("screen_start", screen_start, oldest.start);
					if (cursor_cell !== oldest.cursor)
						report_mismatch("cursor_cell", cursor_cell, oldest.cursor);
					if (beep !== oldest.bell)
						report_mismatch("beep", beep, oldest.bell);
					if (read_cell !== oldest.rd)
						report_mismatch("read_cell", read_cell, oldest.rd);
				end
				results_seen++;
			end
			// long hold-off so the block fills up and stalls its input
			if (hold_on && hold_cnt < HOLD_CYCLES) begin
				out_ready <= 1'b0;
				hold_cnt <= hold_cnt + 1;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
			end
		end
	end

	// Stimulus and phase sequencing
	initial begin
		win_base = '0;
		wr_pos = '0;
		cur_reg = '0;
		col = 0;
		row_idx = 0;
		attr_m = ATTR_RESET;
		blank_m = BLANK_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: print at home and read it back, then clear before any other read
		push_req(REQ_WRITE, 8'h41, 1'b1, '0);
		push_req(REQ_READ, 8'h00, 1'b0, '0);
		push_req(REQ_CLEAR, 8'hFF, 1'b1, '1);
		push_req(REQ_UNUSED, 8'hFF, 1'b1, '1);
		push_req(REQ_WRITE, CH_BS, 1'b1, '0);          // backspace at column 0
		push_req(REQ_WRITE, CH_NUL, 1'b0, '0);
		push_req(REQ_WRITE, CH_ENQ, 1'b0, '0);
		push_req(REQ_WRITE, CH_HT, 1'b0, '0);
		push_req(REQ_WRITE, CH_VT, 1'b0, '0);
		push_req(REQ_WRITE, CH_ESC, 1'b1, '0);
		push_req(REQ_WRITE, CH_BEL, 1'b1, '0);
		push_req(REQ_WRITE, 8'hFF, 1'b0, '1);
		push_req(REQ_WRITE, 8'h80, 1'b0, '0);
		push_req(REQ_WRITE, 8'h20, 1'b1, '0);
		push_req(REQ_WRITE, CH_BS, 1'b1, '0);
		push_req(REQ_WRITE, CH_DEL, 1'b1, '0);
		push_req(REQ_WRITE, CH_CR, 1'b1, '0);
		push_req(REQ_WRITE, CH_LF, 1'b1, '0);
		push_req(REQ_WRITE, CH_FF, 1'b1, '0);
		push_req(REQ_WRITE, 8'h7E, 1'b0, '0);
		push_req(REQ_WRITE, CH_CR, 1'b1, '0);
		push_req(REQ_READ, 8'h00, 1'b0, '0);
		push_req(REQ_READ, 8'h00, 1'b0, '1);
		wait_idle();

		// No idling, both registers at their low extremes
		write_reg(CFG_CHAR_ATTR, 16'h0000);
		write_reg(CFG_BLANK_CELL, 16'h0000);
		gen_traffic(120, 20, 0, 6, 6);
		wait_idle();

		// Sender idling, high extremes; dense line feeds to reach the copy-down
		write_reg(CFG_CHAR_ATTR, 16'h00FF);
		write_reg(CFG_BLANK_CELL, 16'hFFFF);
		src_idle_pct = 53;
		gen_traffic(240, 80, 0, 1, 0);
		wait_idle();

		// Receiver stalling, with one long hold-off at the start
		write_reg(CFG_CHAR_ATTR, cell_t'($urandom_range(0, 255)));
		write_reg(CFG_BLANK_CELL, cell_t'($urandom));
		src_idle_pct = 0;
		snk_stall_pct = 53;
		hold_on = 1'b1;
		gen_traffic(120, 30, 0, 6, 6);
		wait_idle();

		// Both sides idling, clears mixed in
		write_reg(CFG_CHAR_ATTR, cell_t'($urandom_range(0, 255)));
		write_reg(CFG_BLANK_CELL, BLANK_RESET);
		src_idle_pct = 22;
		snk_stall_pct = 22;
		gen_traffic(120, 25, 3, 6, 6);
		wait_idle();

		repeat (20) @(negedge clk);
		if (n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/tcce_pkg.sv
hw/rtl/tcce_ram.sv
hw/rtl/tcce_ctrl.sv
hw/rtl/text_console_cursor_engine_unit.sv
hw/rtl/tcce_checker.sv
sim/tb.sv
